// ===== hdl/prrl_pkg.sv =====
// Shared types and constants for the per-origin repeat rate limiter.
package prrl_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TIME_W = 32;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd43200;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // latch request, clear trackers
    logic rd_en;   // read entry at rd_addr
    logic commit;  // decide and record
  } dp_cmd_t;

  typedef struct packed {
    logic refuse;
  } dp_sts_t;

endpackage

// ===== hdl/prrl_ctrl.sv =====
// Controller: sequences the table walk and the final decision.
module prrl_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 24,
  parameter int unsigned IDX_W         = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_strobe,
  output prrl_pkg::dp_cmd_t    cmd,
  output logic [IDX_W-1:0]     rd_addr
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  prrl_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prrl_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    rd_addr    = cnt_r;
    case (state_r)
      prrl_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = prrl_pkg::ST_SCAN;
        end
      end
      prrl_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = prrl_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // last entry is compared in this cycle
      prrl_pkg::ST_DRAIN: begin
        state_nxt = prrl_pkg::ST_DONE;
      end
      prrl_pkg::ST_DONE: begin
        cmd.commit = 1'b1;
        out_strobe = 1'b1;
        state_nxt  = prrl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = prrl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/prrl_dp.sv =====
// Datapath: key/time table, walk trackers and the allow/refuse decision.
module prrl_dp #(
  parameter int unsigned TABLE_ENTRIES = 24,
  parameter int unsigned KEY_BYTES     = 8,
  parameter int unsigned IDX_W         = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [prrl_pkg::KEY_W-1:0]    in_origin_key,
  input  logic [prrl_pkg::TIME_W-1:0]   in_current_time,
  input  logic                          cfg_we,
  input  logic [prrl_pkg::TIME_W-1:0]   cfg_wdata,
  input  prrl_pkg::dp_cmd_t             cmd,
  input  logic [IDX_W-1:0]              rd_addr,
  output prrl_pkg::dp_sts_t             sts
);

  localparam int unsigned KW = prrl_pkg::KEY_W;
  localparam int unsigned TW = prrl_pkg::TIME_W;
  localparam logic [KW-1:0] KEY_MASK = {KW{1'b1}} << (KW - 8 * KEY_BYTES);

  logic [KW-1:0] mem_key  [TABLE_ENTRIES];
  logic [TW-1:0] mem_time [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [TW-1:0]    window_r;
  logic [KW-1:0]    key_r;
  logic [TW-1:0]    now_r;
  logic [KW-1:0]    rd_key_r;
  logic [TW-1:0]    rd_time_r;
  logic             rd_vld_r;
  logic             cmp_en_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [TW-1:0]    hit_time_r;
  logic [TW-1:0]    min_time_r;
  logic [IDX_W-1:0] min_idx_r;

  logic [KW-1:0]    ent_key;
  logic [TW-1:0]    ent_time;
  logic [TW-1:0]    age;
  logic             refuse;
  logic [IDX_W-1:0] slot;

  // entries not yet written read as zero
  assign ent_key  = rd_vld_r ? rd_key_r  : '0;
  assign ent_time = rd_vld_r ? rd_time_r : '0;

  assign age    = now_r - hit_time_r;
  assign refuse = hit_r && (now_r >= hit_time_r) && (age < window_r);
  assign slot   = hit_r ? hit_idx_r : min_idx_r;
  assign sts.refuse = refuse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= prrl_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd_en;
      if (cmd.commit && !refuse) begin
        valid_r[slot] <= 1'b1;
      end
    end
  end

  // table: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_key_r  <= mem_key[rd_addr];
      rd_time_r <= mem_time[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
      cmp_idx_r <= rd_addr;
    end
    if (cmd.commit && !refuse) begin
      mem_key[slot]  <= key_r;
      mem_time[slot] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r      <= in_origin_key & KEY_MASK;
      now_r      <= in_current_time;
      hit_r      <= 1'b0;
      hit_idx_r  <= '0;
      hit_time_r <= '0;
      min_time_r <= '1;
      min_idx_r  <= '0;
    end else if (cmp_en_r) begin
      // first matching key wins
      if (!hit_r && (ent_key == key_r)) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= cmp_idx_r;
        hit_time_r <= ent_time;
      end
      // strict compare keeps the earliest index on a tie; first empty wins
      if (ent_time < min_time_r) begin
        min_time_r <= ent_time;
        min_idx_r  <= cmp_idx_r;
      end
    end
  end

endmodule

// ===== hdl/per_origin_repeat_rate_limiter.sv =====
// Top level of the per-origin repeat rate limiter.
//
//   channel  ports                                   transfer when
//   in       start, busy, in_origin_key,            start & !busy
//            in_current_time
//   out      out_strobe, out_allowed                 out_strobe (one cycle)
//   cfg      cfg_we, cfg_wdata                       cfg_we
//
// Each request walks the table one entry per cycle through the registered read
// port, then compares the last entry in the drain state and decides in the done
// state. busy stays high from transfer through the result cycle, so a new
// transfer is taken only after the previous result. Synchronous reset empties
// the table at once through per-entry valid bits; the result cannot be held off.
module per_origin_repeat_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 24,
  parameter int unsigned KEY_BYTES     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [prrl_pkg::KEY_W-1:0]    in_origin_key,
  input  logic [prrl_pkg::TIME_W-1:0]   in_current_time,
  output logic                          out_strobe,
  output logic                          out_allowed,
  input  logic                          cfg_we,
  input  logic [prrl_pkg::TIME_W-1:0]   cfg_wdata
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  prrl_pkg::dp_cmd_t cmd;
  prrl_pkg::dp_sts_t sts;
  logic [IDX_W-1:0]  rd_addr;

  prrl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  prrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BYTES     (KEY_BYTES),
    .IDX_W         (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_origin_key   (in_origin_key),
    .in_current_time (in_current_time),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .sts             (sts)
  );

  assign out_allowed = ~sts.refuse;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the per-origin repeat rate limiter.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ENTRIES   = 24;
  localparam int unsigned KEY_BYTES = 8;
  localparam logic [63:0] KEY_MASK  = ~64'd0 << (64 - 8 * KEY_BYTES);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 100;

  // Table model: verdicts are worked out at transfer and queued until the strobe.
  class verdict_board;
    logic [63:0] keys_tbl [ENTRIES];
    logic [31:0] times_tbl[ENTRIES];
    logic [31:0] window;
    bit          verdict_q[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        keys_tbl[i]  = '0;
        times_tbl[i] = '0;
      end
      window = prrl_pkg::WINDOW_RESET;
      errors = 0;
    endfunction

    function bit admit(input logic [63:0] key, input logic [31:0] now);
      bit          hit;
      int          slot;
      int          pick;
      logic [31:0] oldest;
      logic [31:0] gap;
      hit  = 1'b0;
      slot = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!hit && keys_tbl[i] == key) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        gap = now - times_tbl[slot];
        if (now >= times_tbl[slot] && gap < window) return 1'b0;
      end else begin
        // first empty slot, else oldest time with lowest index on a tie
        slot   = -1;
        pick   = 0;
        oldest = 32'hFFFF_FFFF;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0) begin
            if (times_tbl[i] == 0) slot = i;
            else if (times_tbl[i] < oldest) begin
              oldest = times_tbl[i];
              pick   = i;
            end
          end
        end
        if (slot < 0) slot = pick;
      end
      keys_tbl[slot]  = key;
      times_tbl[slot] = now;
      return 1'b1;
    endfunction

    function void note_request(input logic [63:0] key, input logic [31:0] now);
      verdict_q.push_back(admit(key & KEY_MASK, now));
    endfunction

    function void check_verdict(input logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got allowed=%0b", $time, got);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          $display("%0t: allowed mismatch, expected %0b, got %0b", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [63:0] in_origin_key   = '0;
  logic [31:0] in_current_time = '0;
  logic        cfg_we          = 1'b0;
  logic [31:0] cfg_wdata       = '0;
  logic        busy;
  logic        out_strobe;
  logic        out_allowed;

  verdict_board board = new();
  int unsigned  sender_idle = 34;
  int unsigned  cycle_count = 0;
  logic [31:0]  clock_now   = 32'd1000;
  logic [63:0]  key_pool[32];

  always #1 clk = ~clk;

  per_origin_repeat_rate_limiter #(
    .TABLE_ENTRIES(ENTRIES),
    .KEY_BYTES    (KEY_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_origin_key  (in_origin_key),
    .in_current_time(in_current_time),
    .out_strobe     (out_strobe),
    .out_allowed    (out_allowed),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) board.check_verdict(out_allowed);
      if (start && !busy) board.note_request(in_origin_key, in_current_time);
      if (cfg_we) board.window = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold the fields, toggle start at random until the transfer happens.
  task automatic send_request(input logic [63:0] key, input logic [31:0] now);
    in_origin_key   <= key;
    in_current_time <= now;
    do begin
      start <= ($urandom_range(99) >= sender_idle);
      @(posedge clk);
    end while (!(start && !busy));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] next_time(input int unsigned step_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 72) begin
      clock_now += $urandom_range(step_max, 0);
      return clock_now;
    end
    if (r < 80) return $urandom;
    if (r < 85) return 32'd0;
    if (r < 89) return 32'hFFFF_FFFF;
    return clock_now - $urandom_range(step_max, 0);
  endfunction

  function automatic logic [63:0] next_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(31, 0)];
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [31:0] windows[6];
    int unsigned idles[6];
    int unsigned step_max;

    windows = '{32'd100, prrl_pkg::WINDOW_RESET, 32'd0, 32'hFFFF_FFFF,
                $urandom_range(200000, 1), 32'd1};
    idles   = '{34, 34, 48, 48, 0, 0};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key zero hits an empty entry, refused until the time reaches the window
    send_request(64'd0, 32'd100);
    send_request(64'd0, 32'd43200);
    send_request(64'd0, 32'd43201);
    // window boundary and time going backwards
    send_request(64'h0123_4567_89AB_CDEF, 32'd1000);
    send_request(64'h0123_4567_89AB_CDEF, 32'd44199);
    send_request(64'h0123_4567_89AB_CDEF, 32'd44200);
    send_request(64'h0123_4567_89AB_CDEF, 32'd7);
    // a time of zero leaves the entry free for the next new key
    send_request(64'hFEDC_BA98_7654_3210, 32'd0);
    send_request(64'h5555_AAAA_5555_AAAA, 32'd9);
    send_request(64'hFEDC_BA98_7654_3210, 32'd5);
    send_request('1, 32'hFFFF_FFFF);
    send_request('1, 32'd0);
    // fill every entry at the maximum time, then evict with a new key
    for (int i = 0; i < ENTRIES; i++)
      send_request(64'hA5A5_0000_0000_0000 | i, 32'hFFFF_FFFF);
    send_request(64'h3C3C_3C3C_3C3C_3C3C, 32'd12345);

    wait_idle();
    write_window(32'd0);
    send_request(64'h0F0F_0F0F_0F0F_0F0F, 32'd500);
    send_request(64'h0F0F_0F0F_0F0F_0F0F, 32'd500);

    wait_idle();
    write_window(32'hFFFF_FFFF);
    send_request(64'h0F0F_0F0F_0F0F_0F0F, 32'd600);
    send_request(64'h0F0F_0F0F_0F0F_0F0F, 32'hFFFF_FFFF);
    send_request(64'h0F0F_0F0F_0F0F_0F0F, 32'd499);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_window(windows[p]);
      sender_idle = idles[p];
      if (windows[p] == 0 || windows[p] > 32'h4000_0000) step_max = 32'h0010_0000;
      else step_max = windows[p] + (windows[p] >> 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(next_key(), next_time(step_max));
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
